FILE: rtl/core/dense_layer_sigmoid_assert.svh
// Assertion macros for the dense layer block.
// Used by the top level; depends on nothing else.
`ifndef DENSE_LAYER_SIGMOID_ASSERT_SVH
`define DENSE_LAYER_SIGMOID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dense layer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DLS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dense layer assertion failed");

`endif

FILE: rtl/core/dls_pkg.sv
// Shared constants, codes and types of the dense layer block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dls_pkg;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int SIG_AW = 8;
    localparam int SIG_W  = 16;

    localparam int MAX_NEURONS_DEF = 16;
    localparam int MAX_INPUTS_DEF  = 64;

    localparam logic [6:0] INPUTS_RST  = 7'd64;
    localparam logic [4:0] NEURONS_RST = 5'd16;

    localparam logic [31:0] EXP_STEP = 32'd4162825044;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    localparam logic CFG_INPUTS  = 1'b0;
    localparam logic CFG_NEURONS = 1'b1;

    typedef struct packed {
        logic                    vld;
        logic                    use_prod;
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] feature;
        logic signed [ACC_W-1:0] base;
    } dls_mac_req_t;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] acc;
    } dls_mac_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/dls_sig_table.sv
// Sigmoid lookup table, built after reset with one 32x32 multiplier and a
// serial divider, then read through a registered port. Uses dls_pkg.
`default_nettype none

module dls_sig_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dls_pkg::SIG_AW-1:0]  rd_addr,
    output logic      [dls_pkg::SIG_W-1:0]   rd_data,
    output logic                             done
);

    localparam logic [2:0] T_SETUP = 3'd0;
    localparam logic [2:0] T_DIV   = 3'd1;
    localparam logic [2:0] T_WR    = 3'd2;
    localparam logic [2:0] T_MUL   = 3'd3;
    localparam logic [2:0] T_RND   = 3'd4;
    localparam logic [2:0] T_DONE  = 3'd5;

    logic [dls_pkg::SIG_W-1:0] mem [0:(1 << dls_pkg::SIG_AW)-1];

    logic [2:0]  state_reg, state_next;
    logic [31:0] p_reg, p_next;
    logic [7:0]  m_reg, m_next;
    logic        hi_reg, hi_next;
    logic [4:0]  bits_reg, bits_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] low_reg, low_next;
    logic [16:0] q_reg, q_next;
    logic [32:0] d_reg, d_next;
    logic [63:0] prod_reg, prod_next;
    logic [15:0] rd_data_reg;

    logic [48:0] num;
    logic [31:0] half;
    logic [33:0] trial;
    logic        ge;
    logic [63:0] rounded;
    logic [7:0]  wr_addr;
    logic [15:0] wr_data;

    always_comb
    begin
        half    = {1'b1, p_reg[31:1]};
        num     = hi_reg ? ((49'd1 << 48) + 49'(half))
                         : (49'({p_reg, 16'd0}) + 49'(half));
        trial   = {rem_reg[32:0], low_reg[16]};
        ge      = (trial >= {1'b0, d_reg});
        rounded = prod_reg + 64'h0000_0000_8000_0000;
        wr_addr = hi_reg ? {1'b1, m_reg[7:1]} : {1'b0, ~m_reg[7:1]};
        wr_data = (hi_reg && q_reg[16]) ? 16'hFFFF : q_reg[15:0];

        state_next = state_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        hi_next    = hi_reg;
        bits_next  = bits_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;

        case (state_reg)
            T_SETUP:
            begin
                d_next     = {1'b1, p_reg};
                rem_next   = {2'b00, num[48:17]};
                low_next   = num[16:0];
                q_next     = 17'd0;
                bits_next  = 5'd0;
                state_next = T_DIV;
            end
            T_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, d_reg}) : trial;
                low_next  = {low_reg[15:0], 1'b0};
                q_next    = {q_reg[15:0], ge};
                bits_next = bits_reg + 5'd1;
                if (bits_reg == 5'd16)
                begin
                    state_next = T_WR;
                end
            end
            T_WR:
            begin
                if (hi_reg)
                begin
                    hi_next    = 1'b0;
                    state_next = T_SETUP;
                end
                else if (m_reg == 8'd255)
                begin
                    state_next = T_DONE;
                end
                else
                begin
                    state_next = T_MUL;
                end
            end
            T_MUL:
            begin
                prod_next  = 64'(p_reg) * 64'(dls_pkg::EXP_STEP);
                m_next     = m_reg + 8'd1;
                state_next = T_RND;
            end
            T_RND:
            begin
                p_next = rounded[63:32];
                if (m_reg[0])
                begin
                    hi_next    = 1'b1;
                    state_next = T_SETUP;
                end
                else
                begin
                    state_next = T_MUL;
                end
            end
            T_DONE:
            begin
                state_next = T_DONE;
            end
            default:
            begin
                state_next = T_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_SETUP;
            p_reg     <= dls_pkg::EXP_STEP;
            m_reg     <= 8'd1;
            hi_reg    <= 1'b1;
            bits_reg  <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            m_reg     <= m_next;
            hi_reg    <= hi_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_WR)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign done    = (state_reg == T_DONE);

endmodule

`default_nettype wire

FILE: rtl/core/dls_mac.sv
// Shared multiply and saturating accumulate unit, one neuron per cycle.
// Registers the product, then adds it to the base with saturation. Uses dls_pkg.
`default_nettype none

module dls_mac (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dls_pkg::dls_mac_req_t req,
    output dls_pkg::dls_mac_rsp_t      rsp
);

    localparam int AW = dls_pkg::ACC_W;

    logic                              vld_reg;
    logic                              use_reg;
    logic signed [dls_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]              base_reg;

    logic signed [AW:0] addend;
    logic signed [AW:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= req.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        use_reg  <= req.use_prod;
        prod_reg <= req.weight * req.feature;
        base_reg <= req.base;
    end

    always_comb
    begin
        addend = use_reg ? (AW+1)'(prod_reg) : '0;
        sum    = (AW+1)'(base_reg) + addend;
        rsp.vld = vld_reg;
        if (sum[AW] != sum[AW-1])
        begin
            rsp.acc = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        else
        begin
            rsp.acc = sum[AW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dense_layer_sigmoid.sv
// Fully connected layer with sigmoid output: stores, sequencer and handshakes.
// After reset the sigmoid table is built while in_ready is held low.
// A weight or bias write leaves in_ready high. A feature holds in_ready low while the
// neurons in use go through the MAC (all MAX_NEURONS on the first feature of a vector).
// After a last feature each result is read, looked up in the table and held until taken,
// one neuron at a time. An asynchronous rst_n clears control and rebuilds the table.
`default_nettype none
`include "dense_layer_sigmoid_assert.svh"

module dense_layer_sigmoid #(
    parameter int MAX_NEURONS = dls_pkg::MAX_NEURONS_DEF,
    parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          cmd,
    input  wire logic [3:0]          neuron,
    input  wire logic [5:0]          position,
    input  wire logic signed [15:0]  value,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [3:0]               neuron_index,
    output logic [15:0]              activation,
    output logic                     final_res,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [6:0]          cfg_data
);

    localparam int CW     = $clog2(MAX_NEURONS + 1);
    localparam int NIW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int AW     = dls_pkg::ACC_W;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ERD   = 3'd4;
    localparam logic [2:0] S_EIDX  = 3'd5;
    localparam logic [2:0] S_ETAB  = 3'd6;
    localparam logic [2:0] S_EOUT  = 3'd7;

    logic signed [15:0]   weight_mem [0:WDEPTH-1];
    logic signed [15:0]   bias_mem   [0:MAX_NEURONS-1];
    logic signed [AW-1:0] acc_mem    [0:MAX_NEURONS-1];

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          vec_start_reg, vec_start_next;
    logic          start_reg, start_next;
    logic          a_vld_reg, a_vld_next;
    logic          out_valid_reg, out_valid_next;
    logic [6:0]    inp_reg;
    logic [4:0]    nrn_reg;

    logic                 pos_ok_reg;
    logic [5:0]           pos_reg;
    logic signed [15:0]   feat_reg;
    logic                 last_reg;
    logic [NIW-1:0]       a_n_reg;
    logic [NIW-1:0]       b_n_reg;
    logic signed [15:0]   weight_q_reg;
    logic signed [15:0]   bias_q_reg;
    logic signed [AW-1:0] acc_q_reg;
    logic [3:0]           out_idx_reg;
    logic [15:0]          out_act_reg;
    logic                 out_fin_reg;

    logic [CW-1:0]  count;
    logic [CW-1:0]  limit;
    logic           in_acc;
    logic           out_acc;
    logic           pos_ok_in;
    logic           w_wr_ok;
    logic [WAW-1:0] w_wr_addr;
    logic [WAW-1:0] w_rd_addr;
    logic [NIW-1:0] n_idx;
    logic [7:0]     sig_idx;
    logic [15:0]    sig_data;
    logic           tbl_done;

    dls_pkg::dls_mac_req_t mac_req;
    dls_pkg::dls_mac_rsp_t mac_rsp;

    dls_sig_table u_sig_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (sig_idx),
        .rd_data (sig_data),
        .done    (tbl_done)
    );

    dls_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    always_comb
    begin
        if (int'(nrn_reg) > MAX_NEURONS)
        begin
            count = CW'(MAX_NEURONS);
        end
        else
        begin
            count = CW'(nrn_reg);
        end
        limit     = start_reg ? CW'(MAX_NEURONS) : count;
        in_acc    = in_valid && in_ready;
        out_acc   = out_valid_reg && out_ready;
        pos_ok_in = ({1'b0, position} < inp_reg) && (int'(position) < MAX_INPUTS);
        w_wr_ok   = (int'(neuron) < MAX_NEURONS) && (int'(position) < MAX_INPUTS);
        w_wr_addr = WAW'(neuron) * WAW'(MAX_INPUTS) + WAW'(position);
        n_idx     = cnt_reg[NIW-1:0];
        w_rd_addr = WAW'(n_idx) * WAW'(MAX_INPUTS) + WAW'(pos_reg);

        if (acc_q_reg[AW-1:27] == {(AW-27){1'b0}} || acc_q_reg[AW-1:27] == {(AW-27){1'b1}})
        begin
            sig_idx = {~acc_q_reg[27], acc_q_reg[26:20]};
        end
        else
        begin
            sig_idx = acc_q_reg[AW-1] ? 8'd0 : 8'd255;
        end

        mac_req.vld      = a_vld_reg;
        mac_req.use_prod = (CW'(a_n_reg) < count) && pos_ok_reg;
        mac_req.weight   = weight_q_reg;
        mac_req.feature  = feat_reg;
        mac_req.base     = start_reg ? {{12{bias_q_reg[15]}}, bias_q_reg, 12'd0} : acc_q_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        vec_start_next = vec_start_reg;
        start_next     = start_reg;
        a_vld_next     = 1'b0;
        out_valid_next = out_valid_reg;

        case (state_reg)
            S_INIT:
            begin
                if (tbl_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc && cmd == dls_pkg::CMD_FEATURE)
                begin
                    start_next     = vec_start_reg;
                    vec_start_next = last;
                    cnt_next       = '0;
                    state_next     = S_ACC;
                end
            end
            S_ACC:
            begin
                if (cnt_reg < limit)
                begin
                    a_vld_next = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!a_vld_reg && !mac_rsp.vld)
                begin
                    cnt_next = '0;
                    if (last_reg && count != '0)
                    begin
                        state_next = S_ERD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERD:
            begin
                state_next = S_EIDX;
            end
            S_EIDX:
            begin
                state_next = S_ETAB;
            end
            S_ETAB:
            begin
                out_valid_next = 1'b1;
                state_next     = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (out_fin_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            vec_start_reg <= 1'b1;
            start_reg     <= 1'b0;
            a_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            inp_reg       <= dls_pkg::INPUTS_RST;
            nrn_reg       <= dls_pkg::NEURONS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            vec_start_reg <= vec_start_next;
            start_reg     <= start_next;
            a_vld_reg     <= a_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dls_pkg::CFG_INPUTS:
                    begin
                        inp_reg <= cfg_data;
                    end
                    dls_pkg::CFG_NEURONS:
                    begin
                        nrn_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                        nrn_reg <= nrn_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cmd == dls_pkg::CMD_FEATURE)
        begin
            pos_ok_reg <= pos_ok_in;
            pos_reg    <= position;
            feat_reg   <= value;
            last_reg   <= last;
        end
        a_n_reg <= n_idx;
        b_n_reg <= a_n_reg;
        if (state_reg == S_ETAB)
        begin
            out_idx_reg <= 4'(cnt_reg);
            out_act_reg <= sig_data;
            out_fin_reg <= (CW'(cnt_reg + 1'b1) == count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cmd == dls_pkg::CMD_WEIGHT && w_wr_ok)
        begin
            weight_mem[w_wr_addr] <= value;
        end
        if (in_acc && cmd == dls_pkg::CMD_BIAS && int'(neuron) < MAX_NEURONS)
        begin
            bias_mem[NIW'(neuron)] <= value;
        end
        if (mac_rsp.vld)
        begin
            acc_mem[b_n_reg] <= mac_rsp.acc;
        end
        weight_q_reg <= weight_mem[w_rd_addr];
        bias_q_reg   <= bias_mem[n_idx];
        acc_q_reg    <= acc_mem[n_idx];
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign neuron_index = out_idx_reg;
    assign activation   = out_act_reg;
    assign final_res    = out_fin_reg;

    `DLS_ASSERT_IMP(a_out_blocks_in, clk, rst_n, out_valid_reg, !in_ready)
    `DLS_ASSERT_IMP(a_table_first, clk, rst_n, !tbl_done, !in_ready && !out_valid_reg)
    `DLS_ASSERT_IMP(a_mac_in_pass, clk, rst_n, mac_rsp.vld, state_reg == S_ACC || state_reg == S_DRAIN)
    `DLS_ASSERT_NXT(a_final_to_idle, clk, rst_n, out_acc && out_fin_reg, state_reg == S_IDLE)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dense_layer_sigmoid: preloads every bias and the weights at
// positions 0 and 1, runs directed and random vectors under changing register settings.
// Depends on dls_pkg and the dense_layer_sigmoid RTL only.

module tb;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -64'sd549755813888;

    typedef struct packed {
        logic [3:0]  neuron_index;
        logic [15:0] activation;
        logic        final_res;
    } activation_t;

    class activation_scoreboard;
        logic signed [15:0] weights [1024];
        bit                 written [1024];
        logic signed [15:0] biases [16];
        longint             sums [16];
        logic [15:0]        sig_lut [256];
        bit                 vector_open;
        int unsigned        inputs_cfg;
        int unsigned        neurons_cfg;
        activation_t        expected_activations [$];
        int                 mismatches;

        function new();
            longint unsigned p;
            longint unsigned d;
            longint unsigned hi;
            longint unsigned lo;
            int m;
            p = 64'd1 << 32;
            for (m = 1; m <= 255; m++)
            begin
                p = (p * longint'(dls_pkg::EXP_STEP) + (64'd1 << 31)) >> 32;
                if (m % 2 == 1)
                begin
                    d = (64'd1 << 32) + p;
                    hi = ((64'd1 << 48) + d / 2) / d;
                    lo = ((p << 16) + d / 2) / d;
                    if (hi > 65535)
                        hi = 65535;
                    sig_lut[(255 + m) / 2] = 16'(hi);
                    sig_lut[(255 - m) / 2] = 16'(lo);
                end
            end
            vector_open = 1'b0;
            inputs_cfg = dls_pkg::INPUTS_RST;
            neurons_cfg = dls_pkg::NEURONS_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [6:0] data);
            if (idx == dls_pkg::CFG_INPUTS)
                inputs_cfg = data;
            else
                neurons_cfg = data[4:0];
        endfunction

        function int pending();
            return expected_activations.size();
        endfunction

        // A feature at this position reads only weights that were written.
        function bit readable(logic [5:0] pos);
            int unsigned count;
            int n;
            count = (neurons_cfg > 16) ? 16 : neurons_cfg;
            if (pos >= inputs_cfg)
                return 1'b1;
            for (n = 0; n < count; n++)
                if (!written[n * 64 + pos])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_item(logic [1:0] op, logic [3:0] nrn, logic [5:0] pos,
                                logic signed [15:0] val, logic lst);
            int unsigned count;
            int n;
            longint s;
            longint q;
            activation_t res;
            case (op)
                dls_pkg::CMD_WEIGHT:
                begin
                    weights[{nrn, pos}] = val;
                    written[{nrn, pos}] = 1'b1;
                end
                dls_pkg::CMD_BIAS: biases[nrn] = val;
                dls_pkg::CMD_FEATURE:
                begin
                    if (!vector_open)
                    begin
                        for (n = 0; n < 16; n++)
                            sums[n] = longint'(biases[n]) * 4096;
                        vector_open = 1'b1;
                    end
                    count = (neurons_cfg > 16) ? 16 : neurons_cfg;
                    if (pos < inputs_cfg)
                    begin
                        for (n = 0; n < count; n++)
                        begin
                            s = sums[n] + longint'(weights[n * 64 + pos]) * longint'(val);
                            if (s > ACC_HI)
                                s = ACC_HI;
                            if (s < ACC_LO)
                                s = ACC_LO;
                            sums[n] = s;
                        end
                    end
                    if (lst)
                    begin
                        vector_open = 1'b0;
                        for (n = 0; n < count; n++)
                        begin
                            q = (sums[n] >>> 20) + 128;
                            if (q < 0)
                                q = 0;
                            if (q > 255)
                                q = 255;
                            res.neuron_index = 4'(n);
                            res.activation = sig_lut[q];
                            res.final_res = (n + 1 == count);
                            expected_activations = {expected_activations, res};
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_activation(logic [3:0] idx, logic [15:0] act, logic fin);
            activation_t want;
            if (expected_activations.size() == 0)
            begin
                $error("unexpected output: neuron_index %0d activation %0d final_res %0d",
                       idx, act, fin);
                mismatches++;
                return;
            end
            want = expected_activations.pop_front();
            if (idx !== want.neuron_index)
            begin
                $error("neuron_index: expected %0d, got %0d", want.neuron_index, idx);
                mismatches++;
            end
            if (act !== want.activation)
            begin
                $error("activation: expected %0d, got %0d", want.activation, act);
                mismatches++;
            end
            if (fin !== want.final_res)
            begin
                $error("final_res: expected %0d, got %0d", want.final_res, fin);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = CMD_NONE;
    logic [3:0]         neuron = '0;
    logic [5:0]         position = '0;
    logic signed [15:0] value = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         neuron_index;
    logic [15:0]        activation;
    logic               final_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [6:0]         cfg_data = '0;

    int send_idle_pct = 11;
    int recv_idle_pct = 85;

    activation_scoreboard board = new();

    dense_layer_sigmoid dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .neuron       (neuron),
        .position     (position),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .neuron_index (neuron_index),
        .activation   (activation),
        .final_res    (final_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_activation(neuron_index, activation, final_res);

    task automatic send_item(input logic [1:0] op, input logic [3:0] nrn,
                             input logic [5:0] pos, input logic signed [15:0] val,
                             input logic lst);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        neuron <= nrn;
        position <= pos;
        value <= val;
        last <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(op, nrn, pos, val, lst);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [6:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(7))
            0, 1: return 16'($urandom);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(2047)) - 16'd1024;
        endcase
    endfunction

    // Positions 0 and 1 hold a weight for every neuron from the preload on.
    function automatic logic [5:0] pick_position();
        logic [5:0] pos;
        pos = 6'($urandom);
        if (!board.readable(pos))
            pos = 6'($urandom_range(1));
        return pos;
    endfunction

    task automatic random_vectors(input int budget);
        int k;
        int roll;
        logic [5:0] pos;
        for (k = 0; k < budget; k++)
        begin
            roll = $urandom_range(99);
            if (k == budget - 1)
                roll = 99;
            if (roll < 5)
                send_item(CMD_NONE, 4'($urandom), 6'($urandom), 16'($urandom),
                          1'($urandom));
            else if (roll < 15)
                send_item(dls_pkg::CMD_WEIGHT, 4'($urandom), 6'($urandom), rand_value(),
                          1'($urandom));
            else if (roll < 22)
                send_item(dls_pkg::CMD_BIAS, 4'($urandom), 6'($urandom), rand_value(),
                          1'($urandom));
            else
            begin
                pos = pick_position();
                send_item(dls_pkg::CMD_FEATURE, 4'($urandom), pos, rand_value(),
                          ($urandom_range(2) == 0) || (k == budget - 1));
            end
        end
    endtask

    initial
    begin
        int n;
        int p;
        int ph;
        logic [6:0] ins;
        logic [6:0] nrns;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every bias and the weights at positions 0 and 1 are written first.
        for (n = 0; n < 16; n++)
            send_item(dls_pkg::CMD_BIAS, 4'(n), 6'($urandom), 16'($urandom), 1'($urandom));
        for (n = 0; n < 16; n++)
            for (p = 0; p < 2; p++)
                send_item(dls_pkg::CMD_WEIGHT, 4'(n), 6'(p), rand_value(), 1'($urandom));

        send_item(dls_pkg::CMD_WEIGHT, 4'd15, 6'd1, 16'sh8000, 1'b1);
        send_item(dls_pkg::CMD_WEIGHT, 4'd0, 6'd0, 16'sh7fff, 1'b1);
        send_item(dls_pkg::CMD_BIAS, 4'd15, 6'd63, 16'sh7fff, 1'b1);
        send_item(dls_pkg::CMD_BIAS, 4'd0, 6'd0, 16'sh8000, 1'b0);
        send_item(CMD_NONE, 4'd15, 6'd63, 16'shffff, 1'b1);
        send_item(dls_pkg::CMD_FEATURE, 4'd0, 6'd0, 16'sh7fff, 1'b0);
        send_item(dls_pkg::CMD_FEATURE, 4'd15, 6'd1, 16'sh8000, 1'b0);
        // A bias written inside a vector only counts from the next vector,
        // while a weight written inside a vector is used at once.
        send_item(dls_pkg::CMD_BIAS, 4'd3, 6'd0, 16'sh4000, 1'b0);
        send_item(dls_pkg::CMD_WEIGHT, 4'd2, 6'd1, 16'sh0123, 1'b0);
        send_item(dls_pkg::CMD_FEATURE, 4'd0, 6'd1, 16'sh0400, 1'b1);
        send_item(dls_pkg::CMD_FEATURE, 4'd7, 6'd0, 16'sh0001, 1'b1);

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin ins = 7'd1;   nrns = 7'd1;   end
                1: begin ins = 7'd127; nrns = 7'd31;  end
                2: begin ins = 7'd0;   nrns = 7'd0;   end
                3: begin ins = 7'd64;  nrns = 7'd16;  end
                4: begin ins = 7'($urandom_range(1, 64)); nrns = 7'd100; end
                5: begin ins = 7'd65;  nrns = 7'd17;  end
                6: begin ins = 7'($urandom_range(127)); nrns = 7'($urandom_range(31)); end
                default: begin ins = 7'($urandom_range(1, 64)); nrns = 7'($urandom_range(1, 16)); end
            endcase
            wait_idle();
            if (ph < 3)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 85;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(dls_pkg::CFG_INPUTS, ins);
            write_register(dls_pkg::CFG_NEURONS, nrns);
            random_vectors(9);
        end

        wait_idle();
        if (board.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
